// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define SSFD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define SSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== rtl/ssfd_pkg.sv =====
// Shared types and constants for the start/stop frame deframer.
// No dependencies; used by the interfaces, the framer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ssfd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAYLOAD_LEN = 5;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef byte_t [PAYLOAD_LEN-1:0] payload_t;

  // Register indexes on the configuration channel
  localparam cfg_idx_t REG_START_VALUE = 2'd0;
  localparam cfg_idx_t REG_STOP_VALUE  = 2'd1;

  localparam byte_t START_VALUE_RST = 8'hFF;
  localparam byte_t STOP_VALUE_RST  = 8'hFE;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_P1   = 3'd1,
    PH_P2   = 3'd2,
    PH_P3   = 3'd3,
    PH_P4   = 3'd4,
    PH_P5   = 3'd5,
    PH_STOP = 3'd6
  } phase_t;

endpackage

`default_nettype wire

// ===== rtl/ssfd_if.sv =====
// Channel interfaces of the deframer: received bytes, frames and config writes.
// Depends on ssfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ssfd_byte_if;
  import ssfd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssfd_frame_if;
  import ssfd_pkg::*;
  logic  valid;
  logic  ready;
  byte_t payload_first;
  byte_t payload_second;
  byte_t payload_third;
  byte_t payload_fourth;
  byte_t payload_fifth;
  modport source (output valid, output payload_first, output payload_second,
                  output payload_third, output payload_fourth,
                  output payload_fifth, input ready);
  modport sink   (input valid, input payload_first, input payload_second,
                  input payload_third, input payload_fourth,
                  input payload_fifth, output ready);
endinterface

interface ssfd_cfg_if;
  import ssfd_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  byte_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/start_stop_frame_deframer_top.sv =====
// Top level of the start/stop frame deframer: byte input register, framer,
// frame output register and configuration registers. Depends on ssfd_pkg,
// ssfd_if, ssfd_framer and assert_macros.svh.
//
// Usage:
//   rx    - received bytes, one per transfer (valid/ready).
//   frame - one transfer per good frame: start byte, five payload bytes and
//           a stop byte that matches stop_value; carries the five payload bytes.
//   cfg   - register writes: index 0 start_value, index 1 stop_value;
//           other indexes are ignored. Always ready. Write only while idle.
// A byte equal to start_value restarts the frame at any point; a wrong stop
// byte drops the frame without any output.
// A frame enters the output register as its stop byte leaves the input register.
// Throughput: one byte per cycle while frame does not stall; the input and output
// registers hold one item each, so a byte is taken while a finished frame waits.
// When frame stalls, the input register holds its byte and rx stops taking
// bytes once that register is full.
// Reset (rst, synchronous): registers go to 255 and 254, the framer waits for
// a start byte, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module start_stop_frame_deframer_top (
  input  wire logic   clk,
  input  wire logic   rst,
  ssfd_byte_if.sink   rx,
  ssfd_frame_if.source frame,
  ssfd_cfg_if.sink    cfg
);
  import ssfd_pkg::*;

  byte_t    start_value;
  byte_t    stop_value;
  logic     in_valid;
  byte_t    in_byte;
  logic     advance;
  logic     step;
  logic     frame_done;
  payload_t payload;
  logic     out_valid;
  payload_t out_payload;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= START_VALUE_RST;
      stop_value  <= STOP_VALUE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_START_VALUE: start_value <= cfg.data;
        REG_STOP_VALUE:  stop_value  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Stage moves when the output register is free or being emptied
  assign advance  = !out_valid || frame.ready;
  assign step     = in_valid && advance;
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  ssfd_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (in_byte),
    .start_value (start_value),
    .stop_value  (stop_value),
    .frame_done  (frame_done),
    .payload     (payload)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      out_payload <= payload;
    end
  end

  assign frame.valid          = out_valid;
  assign frame.payload_first  = out_payload[0];
  assign frame.payload_second = out_payload[1];
  assign frame.payload_third  = out_payload[2];
  assign frame.payload_fourth = out_payload[3];
  assign frame.payload_fifth  = out_payload[4];

  `SSFD_ASSERT_NEXT(a_rx_lands, clk, rst, rx.valid && rx.ready, in_valid)
  `SSFD_ASSERT_NEXT(a_hold_byte, clk, rst, in_valid && !advance, in_valid && $stable(in_byte))
  `SSFD_ASSERT_NEXT(a_frame_out, clk, rst, frame_done, out_valid && $stable(start_value))
  `SSFD_ASSERT_SAME(a_done_step, clk, rst, frame_done, step)

endmodule

`default_nettype wire

// ===== rtl/ssfd_framer.sv =====
// Frame phase tracker and payload collector of the deframer.
// Depends on ssfd_pkg; instantiated by start_stop_frame_deframer_top.
`timescale 1ns / 1ps
`default_nettype none

module ssfd_framer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire ssfd_pkg::byte_t    rx_byte,
  input  wire ssfd_pkg::byte_t    start_value,
  input  wire ssfd_pkg::byte_t    stop_value,
  output logic                frame_done,
  output ssfd_pkg::payload_t  payload
);
  import ssfd_pkg::*;

  phase_t   phase;
  phase_t   phase_next;
  payload_t partial;
  logic     is_start;

  assign is_start = (rx_byte == start_value);

  // Next phase
  always_comb begin
    case (phase)
      PH_P1:   phase_next = PH_P2;
      PH_P2:   phase_next = PH_P3;
      PH_P3:   phase_next = PH_P4;
      PH_P4:   phase_next = PH_P5;
      PH_P5:   phase_next = PH_STOP;
      default: phase_next = PH_IDLE;
    endcase
    // A start byte restarts collection from any phase
    if (is_start) begin
      phase_next = PH_P1;
    end
  end

  // Outputs
  always_comb begin
    frame_done = 1'b0;
    case (phase)
      PH_STOP: frame_done = step && (rx_byte == stop_value);
      default: frame_done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // Payload slots need no reset: a frame is emitted only after all five are written
  always_ff @(posedge clk) begin
    if (step) begin
      case (phase)
        PH_P1:   partial[0] <= rx_byte;
        PH_P2:   partial[1] <= rx_byte;
        PH_P3:   partial[2] <= rx_byte;
        PH_P4:   partial[3] <= rx_byte;
        PH_P5:   partial[4] <= rx_byte;
        default: ;
      endcase
    end
  end

  assign payload = partial;

endmodule

`default_nettype wire
